[design/dfa_pkg.sv]
package dfa_pkg;

  // Default size of the automaton.
  localparam int DEF_NUM_STATES  = 64;
  localparam int DEF_NUM_SYMBOLS = 8;

  // Fixed field widths of the channels.
  localparam int CMD_W    = 2;
  localparam int ROW_W    = 6;
  localparam int COL_W    = 3;
  localparam int NEXT_W   = 6;
  localparam int BYTE_W   = 8;
  localparam int FSTATE_W = 6;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  // Configuration register widths and reset values.
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam int START_W    = 6;
  localparam int MASK_W     = 64;
  localparam int COUNT_W    = 4;
  localparam int CHARS_W    = 64;
  localparam logic [START_W-1:0] START_RST = '0;
  localparam logic [MASK_W-1:0]  MASK_RST  = 64'h1;
  localparam logic [COUNT_W-1:0] COUNT_RST = 4'd2;
  localparam logic [CHARS_W-1:0] CHARS_RST = 64'h3130;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_SYM  = 2'd1,
    CMD_END  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_START = 2'd0,
    REG_MASK  = 2'd1,
    REG_COUNT = 2'd2,
    REG_CHARS = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                accepted;
    logic [FSTATE_W-1:0] final_state;
    logic                bad_symbol;
  } result_t;

endpackage

[design/dfa_col.sv]
module dfa_col import dfa_pkg::*; #(
  parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS,
  parameter int SYM_W       = 3
) (
  input  logic [BYTE_W-1:0]  symbol_byte,
  input  logic [CHARS_W-1:0] symbol_chars,
  input  logic [COUNT_W-1:0] symbol_count,
  output logic               hit,
  output logic [SYM_W-1:0]   col
);

  // Scanning from the top down leaves the lowest matching column selected.
  always_comb begin
    hit = 1'b0;
    col = '0;
    for (int c = NUM_SYMBOLS - 1; c >= 0; c--) begin
      if ((COUNT_W'(c) < symbol_count) &&
          (symbol_chars[c*BYTE_W +: BYTE_W] == symbol_byte)) begin
        hit = 1'b1;
        col = SYM_W'(c);
      end
    end
  end

endmodule

[design/dfa_tbl.sv]
module dfa_tbl import dfa_pkg::*; #(
  parameter int STATE_W    = 6,
  parameter int ADDR_W     = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [STATE_W-1:0] wdata,
  input  logic               re,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [STATE_W-1:0] rdata,
  output logic               clr_busy
);

  localparam int DEPTH = 1 << ADDR_W;
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

  logic [STATE_W-1:0] mem [DEPTH];
  logic [STATE_W-1:0] rdata_r;
  logic               clr_busy_r, clr_busy_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;

  // After reset every entry is swept to state zero, one per cycle.
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == LAST) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata    = rdata_r;
  assign clr_busy = clr_busy_r;

endmodule

[design/table_driven_dfa_matcher_unit.sv]
// Channel  | Direction | Transfer carries
// in_*     | input     | tuser: cmd; tdata: table_state, table_symbol, table_next, symbol_byte
// out_*    | output    | tdata: accepted, final_state, bad_symbol (end of string only)
// cfg_*    | input     | cfg_addr: register index; cfg_data: value; always ready
//
// One input transfer is taken every cycle while in_tready is high. The transition table
// read data is registered and feeds the next table address directly, so symbols chain at
// one per cycle while taken; an end-of-string result goes to the output register, or to the
// skid entry when that is full. After reset the table's 2^(state bits + column bits) entries
// (512 by default) are swept to zero with in_tready low; configuration writes are taken.
// Results sit in a two-entry buffer; after the sweep, in_tready drops only when both are full.
module table_driven_dfa_matcher_unit import dfa_pkg::*; #(
  parameter int NUM_STATES  = DEF_NUM_STATES,
  parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [5:0] table_state, [8:6] table_symbol, [14:9] table_next, [22:15] symbol_byte
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] cmd
  input  logic [CMD_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] accepted, [6:1] final_state, [7] bad_symbol
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int STATE_W = $clog2(NUM_STATES);
  localparam int SYM_W   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int ADDR_W  = STATE_W + SYM_W;
  localparam logic [STATE_W-1:0] LAST_STATE = STATE_W'(NUM_STATES - 1);

  // Configuration registers.
  logic [START_W-1:0] start_r;
  logic [MASK_W-1:0]  mask_r;
  logic [COUNT_W-1:0] count_r;
  logic [CHARS_W-1:0] chars_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_RST;
      mask_r  <= MASK_RST;
      count_r <= COUNT_RST;
      chars_r <= CHARS_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_addr))
        REG_START: start_r <= cfg_data[START_W-1:0];
        REG_MASK:  mask_r  <= cfg_data[MASK_W-1:0];
        REG_COUNT: count_r <= cfg_data[COUNT_W-1:0];
        REG_CHARS: chars_r <= cfg_data[CHARS_W-1:0];
        default:   ;
      endcase
    end
  end

  // Input fields.
  cmd_t              cmd;
  logic [ROW_W-1:0]  f_row;
  logic [COL_W-1:0]  f_col;
  logic [NEXT_W-1:0] f_next;
  logic [BYTE_W-1:0] f_byte;

  assign cmd    = cmd_t'(in_tuser);
  assign f_row  = in_tdata[5:0];
  assign f_col  = in_tdata[8:6];
  assign f_next = in_tdata[14:9];
  assign f_byte = in_tdata[22:15];

  logic clr_busy;
  logic in_acc;
  logic skid_v_r, skid_v_nxt;
  logic res_v_r, res_v_nxt;
  result_t res_r, res_nxt, skid_r, skid_nxt, new_res;

  assign in_tready = !clr_busy && !skid_v_r;
  assign in_acc    = in_tvalid && in_tready;

  // Walk state: when pend_r is set the current state is the table read data.
  logic [STATE_W-1:0] state_r, state_nxt;
  logic               pend_r, pend_nxt;
  logic               instr_r, instr_nxt;
  logic               bad_r, bad_nxt;
  logic [STATE_W-1:0] rdata, cur, base, eff_start;
  logic               hit;
  logic [SYM_W-1:0]   col;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [STATE_W-1:0] wdata;
  logic               load_ok;

  assign eff_start = ((START_W + 1)'(start_r) < (START_W + 1)'(NUM_STATES)) ?
                     start_r[STATE_W-1:0] : LAST_STATE;
  assign cur       = pend_r ? rdata : state_r;
  assign base      = instr_r ? cur : eff_start;

  dfa_col #(
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .SYM_W       (SYM_W)
  ) u_col (
    .symbol_byte  (f_byte),
    .symbol_chars (chars_r),
    .symbol_count (count_r),
    .hit          (hit),
    .col          (col)
  );

  assign load_ok = ((ROW_W + 1)'(f_row) < (ROW_W + 1)'(NUM_STATES)) &&
                   ((COL_W + 1)'(f_col) < (COL_W + 1)'(NUM_SYMBOLS)) &&
                   ((NEXT_W + 1)'(f_next) < (NEXT_W + 1)'(NUM_STATES));
  assign mem_we  = in_acc && (cmd == CMD_LOAD) && load_ok;
  assign waddr   = {f_row[STATE_W-1:0], f_col[SYM_W-1:0]};
  assign wdata   = f_next[STATE_W-1:0];
  assign mem_re  = in_acc && (cmd == CMD_SYM) && hit;
  assign raddr   = {base, col};

  dfa_tbl #(
    .STATE_W    (STATE_W),
    .ADDR_W     (ADDR_W)
  ) u_tbl (
    .clk      (clk),
    .rst_n    (rst_n),
    .we       (mem_we),
    .waddr    (waddr),
    .wdata    (wdata),
    .re       (mem_re),
    .raddr    (raddr),
    .rdata    (rdata),
    .clr_busy (clr_busy)
  );

  always_comb begin
    state_nxt = cur;
    pend_nxt  = 1'b0;
    instr_nxt = instr_r;
    bad_nxt   = bad_r;
    new_res.final_state = FSTATE_W'(base);
    new_res.bad_symbol  = instr_r && bad_r;
    new_res.accepted    = mask_r[FSTATE_W'(base)] && !(instr_r && bad_r);
    if (in_acc) begin
      case (cmd)
        CMD_SYM: begin
          instr_nxt = 1'b1;
          bad_nxt   = (instr_r && bad_r) || !hit;
          state_nxt = base;
          pend_nxt  = hit;
        end
        CMD_END: begin
          instr_nxt = 1'b0;
          bad_nxt   = 1'b0;
          state_nxt = eff_start;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      pend_r  <= 1'b0;
      instr_r <= 1'b0;
      bad_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      instr_r <= instr_nxt;
      bad_r   <= bad_nxt;
    end
  end

  // Two-entry result buffer: output register plus a skid entry behind it.
  logic push, pop;

  assign push = in_acc && (cmd == CMD_END);
  assign pop  = res_v_r && out_tready;

  always_comb begin
    res_v_nxt  = res_v_r;
    res_nxt    = res_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (pop) begin
      if (skid_v_r) begin
        res_nxt    = skid_r;
        skid_v_nxt = push;
        skid_nxt   = new_res;
      end else if (push) begin
        res_nxt = new_res;
      end else begin
        res_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!res_v_r) begin
        res_v_nxt = 1'b1;
        res_nxt   = new_res;
      end else begin
        skid_v_nxt = 1'b1;
        skid_nxt   = new_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      res_v_r  <= res_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = res_v_r;
  assign out_tdata  = {res_r.bad_symbol, res_r.final_state, res_r.accepted};

  // The table sweep must finish before any item is taken.
  a_no_item_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_tready)
    else $error("input taken during table clear");

  // A pending table read only follows a symbol transfer.
  a_pend_after_sym: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(pend_r) |-> $past(in_acc) && ($past(cmd) == CMD_SYM))
    else $error("pending read without symbol transfer");

  // The skid entry is used only behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> res_v_r)
    else $error("skid entry valid while output empty");

  // An end-of-string transfer always leaves a result waiting.
  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_tvalid)
    else $error("end of string gave no result");

endmodule

[tb/sv/dfa_matcher_checker.sv]
`timescale 1ns / 100ps

module dfa_matcher_checker
  import dfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [CMD_W-1:0]      in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    results_pending,
  output int                    results_checked,
  output int                    strings_accepted,
  output int                    strings_with_bad
);

  localparam int TABLE_DEPTH = DEF_NUM_STATES * DEF_NUM_SYMBOLS;

  logic [NEXT_W-1:0]   next_state_of [TABLE_DEPTH];
  logic [START_W-1:0]  start_reg;
  logic [MASK_W-1:0]   mask_reg;
  logic [COUNT_W-1:0]  count_reg;
  logic [CHARS_W-1:0]  chars_reg;
  logic [FSTATE_W-1:0] cur_state;
  logic                mid_string;
  logic                saw_bad;
  result_t             verdict_q[$];

  task automatic report_mismatch(input string msg);
    $display("[%0t ns] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Advances the automaton by one input transfer and queues the verdict of an end item.
  task automatic step_automaton(input logic [CMD_W-1:0] cmd, input logic [IN_DATA_W-1:0] data);
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [NEXT_W-1:0]   nxt;
    logic [BYTE_W-1:0]   sym;
    logic [FSTATE_W-1:0] fin;
    int                  ncols;
    int                  hit;
    result_t             res;
    row = data[5:0];
    col = data[8:6];
    nxt = data[14:9];
    sym = data[22:15];
    ncols = (count_reg > DEF_NUM_SYMBOLS) ? DEF_NUM_SYMBOLS : int'(count_reg);
    // The start register is as wide as the state index, so it is never out of range here.
    case (cmd_t'(cmd))
      CMD_LOAD: next_state_of[{row, col}] = nxt;
      CMD_SYM: begin
        if (!mid_string) begin
          cur_state  = start_reg;
          saw_bad    = 1'b0;
          mid_string = 1'b1;
        end
        hit = -1;
        // Scan downward so that the lowest matching column wins.
        for (int c = ncols - 1; c >= 0; c--) begin
          if (chars_reg[8*c +: 8] == sym) hit = c;
        end
        if (hit < 0) saw_bad = 1'b1;
        else cur_state = next_state_of[{cur_state, hit[COL_W-1:0]}];
      end
      CMD_END: begin
        fin = mid_string ? cur_state : start_reg;
        res.accepted    = mask_reg[fin] && !saw_bad;
        res.final_state = fin;
        res.bad_symbol  = saw_bad;
        verdict_q = {verdict_q, res};
        mid_string = 1'b0;
        saw_bad    = 1'b0;
        cur_state  = start_reg;
      end
      default: ;
    endcase
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] data);
    result_t want;
    if (verdict_q.size() == 0) begin
      report_mismatch($sformatf("result %h with no end of string outstanding", data));
      return;
    end
    want = verdict_q.pop_front();
    results_checked++;
    if (data[0] !== want.accepted)
      report_mismatch($sformatf("accepted got %b expected %b", data[0], want.accepted));
    if (data[6:1] !== want.final_state)
      report_mismatch($sformatf("final_state got %0d expected %0d", data[6:1], want.final_state));
    if (data[7] !== want.bad_symbol)
      report_mismatch($sformatf("bad_symbol got %b expected %b", data[7], want.bad_symbol));
    if (want.accepted) strings_accepted++;
    if (want.bad_symbol) strings_with_bad++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) next_state_of[i] = '0;
      start_reg  = START_RST;
      mask_reg   = MASK_RST;
      count_reg  = COUNT_RST;
      chars_reg  = CHARS_RST;
      cur_state  = '0;
      mid_string = 1'b0;
      saw_bad    = 1'b0;
      verdict_q.delete();
      fail_count       = 0;
      results_checked  = 0;
      strings_accepted = 0;
      strings_with_bad = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_addr))
          REG_START: start_reg = cfg_data[START_W-1:0];
          REG_MASK:  mask_reg  = cfg_data;
          REG_COUNT: count_reg = cfg_data[COUNT_W-1:0];
          REG_CHARS: chars_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) step_automaton(in_tuser, in_tdata);
      if (out_tvalid && out_tready) check_result(out_tdata);
    end
    results_pending = verdict_q.size();
  end

endmodule

[tb/sv/tb_table_driven_dfa_matcher_unit.sv]
`timescale 1ns / 100ps

module tb_table_driven_dfa_matcher_unit;
  import dfa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1850;
  localparam int CALM_AFTER  = 1600;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]      in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic in_fire = 1'b0;
  logic cfg_fire = 1'b0;

  int fail_count;
  int results_pending;
  int results_checked;
  int strings_accepted;
  int strings_with_bad;

  int   items_sent = 0;
  int   settings_used = 0;
  int   send_gap_rate = 8;
  int   stall_rate = 8;
  int   stall_left = 0;
  logic quiet = 1'b0;

  // Alphabet as currently programmed, used to build strings that walk the table.
  logic [BYTE_W-1:0] alpha [DEF_NUM_SYMBOLS];
  int                alpha_n;

  table_driven_dfa_matcher_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  dfa_matcher_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_addr         (cfg_addr),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .results_pending  (results_pending),
    .results_checked  (results_checked),
    .strings_accepted (strings_accepted),
    .strings_with_bad (strings_with_bad)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Transfer flags are registered at the rising edge and read by the stimulus at the falling edge.
  always @(posedge clk) begin
    in_fire  <= in_tvalid && in_tready;
    cfg_fire <= cfg_valid && cfg_ready;
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (!quiet && stall_rate != 0 && $urandom_range(63) < stall_rate) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(14);
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_fields(input logic [ROW_W-1:0] row,
                                                       input logic [COL_W-1:0] col,
                                                       input logic [NEXT_W-1:0] nxt,
                                                       input logic [BYTE_W-1:0] sym);
    return {1'b0, sym, nxt, col, row};
  endfunction

  function automatic logic [IN_DATA_W-1:0] random_fields();
    return pack_fields(ROW_W'($urandom_range(63)), COL_W'($urandom_range(7)),
                       NEXT_W'($urandom_range(63)), BYTE_W'($urandom_range(255)));
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer, valid still high.
  task automatic push_xfer(input logic [CMD_W-1:0] cmd, input logic [IN_DATA_W-1:0] data);
    if (!quiet && send_gap_rate != 0 && $urandom_range(63) < send_gap_rate) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(negedge clk);
    end
    in_tuser  <= cmd;
    in_tdata  <= data;
    in_tvalid <= 1'b1;
    do @(negedge clk); while (!in_fire);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic load_entry(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                            input logic [NEXT_W-1:0] nxt);
    push_xfer(CMD_LOAD, pack_fields(row, col, nxt, BYTE_W'($urandom_range(255))));
  endtask

  task automatic feed_byte(input logic [BYTE_W-1:0] sym);
    push_xfer(CMD_SYM, pack_fields(ROW_W'($urandom_range(63)), COL_W'($urandom_range(7)),
                                   NEXT_W'($urandom_range(63)), sym));
  endtask

  task automatic close_string();
    push_xfer(CMD_END, random_fields());
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_addr  <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_fire);
  endtask

  // Registers change only with the input side quiet and every verdict delivered.
  task automatic reconfigure(input logic [START_W-1:0] st, input logic [MASK_W-1:0] mk,
                             input logic [COUNT_W-1:0] cnt, input logic [CHARS_W-1:0] ch);
    logic [CFG_DATA_W-1:0] junk;
    junk = {$urandom(), $urandom()};
    in_tvalid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    // Symbol and load transfers leave no result, so give the pipeline time to drain.
    repeat (8) @(negedge clk);
    write_reg(REG_START, {junk[CFG_DATA_W-1:START_W], st});
    write_reg(REG_MASK, mk);
    write_reg(REG_COUNT, {junk[CFG_DATA_W-1:COUNT_W], cnt});
    write_reg(REG_CHARS, ch);
    cfg_valid <= 1'b0;
    for (int i = 0; i < DEF_NUM_SYMBOLS; i++) alpha[i] = ch[8*i +: 8];
    alpha_n = (cnt > DEF_NUM_SYMBOLS) ? DEF_NUM_SYMBOLS : int'(cnt);
    settings_used++;
  endtask

  task automatic run_random_phase();
    logic [START_W-1:0] st;
    logic [MASK_W-1:0]  mk;
    logic [COUNT_W-1:0] cnt;
    logic [CHARS_W-1:0] ch;
    int                 live;
    int                 pick;
    case ($urandom_range(3))
      0: st = '0;
      1: st = '1;
      default: st = START_W'($urandom_range(63));
    endcase
    case ($urandom_range(4))
      0: mk = '0;
      1: mk = '1;
      2: mk = {$urandom(), $urandom()} & {$urandom(), $urandom()};
      default: mk = {$urandom(), $urandom()};
    endcase
    pick = $urandom_range(9);
    if (pick == 0) cnt = '0;
    else if (pick == 1) cnt = COUNT_W'($urandom_range(15, 9));
    else cnt = COUNT_W'($urandom_range(8, 1));
    ch = {$urandom(), $urandom()};
    // Repeated alphabet bytes check that the lowest column is the one taken.
    if ($urandom_range(3) == 0) ch[15:8] = ch[7:0];
    if ($urandom_range(3) == 0) ch[63:56] = ch[23:16];
    reconfigure(st, mk, cnt, ch);
    case ($urandom_range(2))
      0: send_gap_rate <= 0;
      1: send_gap_rate <= 4;
      default: send_gap_rate <= 16;
    endcase
    case ($urandom_range(2))
      0: stall_rate <= 0;
      1: stall_rate <= 4;
      default: stall_rate <= 16;
    endcase

    // Keep most loads inside a live set of states so that strings traverse programmed entries.
    live = $urandom_range(64, 2);
    repeat ($urandom_range(48, 8)) begin
      if ($urandom_range(7) == 0)
        load_entry(ROW_W'($urandom_range(63)), COL_W'($urandom_range(7)),
                   NEXT_W'($urandom_range(63)));
      else
        load_entry(ROW_W'($urandom_range(live - 1)),
                   COL_W'($urandom_range(alpha_n > 0 ? alpha_n - 1 : 0)),
                   NEXT_W'($urandom_range(live - 1)));
    end
    repeat ($urandom_range(16, 6)) begin
      repeat ($urandom_range(10)) begin
        pick = $urandom_range(31);
        if (pick == 0) push_xfer(CMD_UNUSED, random_fields());
        else if (pick == 1)
          load_entry(ROW_W'($urandom_range(live - 1)), COL_W'($urandom_range(7)),
                     NEXT_W'($urandom_range(live - 1)));
        else if (pick <= 3 || alpha_n == 0) feed_byte(BYTE_W'($urandom_range(255)));
        else feed_byte(alpha[$urandom_range(alpha_n - 1)]);
      end
      close_string();
    end
  endtask

  initial begin
    for (int i = 0; i < DEF_NUM_SYMBOLS; i++) alpha[i] = CHARS_RST[8*i +: 8];
    alpha_n = COUNT_RST;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Reset configuration and an all-zero table: empty string, a bad byte, an unused command.
    close_string();
    feed_byte(8'h31);
    feed_byte(8'h78);
    close_string();
    push_xfer(CMD_UNUSED, random_fields());

    // Highest start state and table corners; a load lands in the middle of a string.
    reconfigure('1, 64'h8000_0000_0000_0001, 4'd8, 64'hFF7F_8041_3130_0100);
    load_entry(6'd63, 3'd7, 6'd63);
    load_entry(6'd0, 3'd0, 6'd0);
    load_entry(6'd63, 3'd0, 6'd0);
    load_entry(6'd0, 3'd7, 6'd5);
    feed_byte(8'hFF);
    close_string();
    close_string();
    feed_byte(8'h00);
    feed_byte(8'hFF);
    load_entry(6'd5, 3'd3, 6'd42);
    feed_byte(8'h31);
    close_string();

    // An empty alphabet makes every byte bad.
    reconfigure('0, '1, 4'd0, 64'hFF7F_8041_3130_0100);
    feed_byte(8'h00);
    close_string();

    // A count above the table width acts as the full width; repeated bytes pick column 0.
    reconfigure(6'd1, '0, 4'd15, 64'hFF00_0000_0000_4141);
    load_entry(6'd1, 3'd1, 6'd9);
    load_entry(6'd1, 3'd0, 6'd7);
    feed_byte(8'h41);
    feed_byte(8'hFF);
    close_string();

    while (items_sent < ITEM_TARGET) begin
      if (items_sent > CALM_AFTER) quiet <= 1'b1;
      run_random_phase();
    end

    in_tvalid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("Run covered %0d input transfers under %0d register settings.",
             items_sent, settings_used);
    $display("%0d string verdicts checked: %0d accepted, %0d with an out-of-alphabet byte.",
             results_checked, strings_accepted, strings_with_bad);
    if (fail_count == 0) begin
      $display("table_driven_dfa_matcher_unit test passed");
    end else begin
      $display("table_driven_dfa_matcher_unit test failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d verdicts outstanding.", results_pending);
    $display("table_driven_dfa_matcher_unit test failed");
    $finish;
  end

endmodule
